// ===== src/rdrl_pkg.sv =====
`default_nettype none

package rdrl_pkg;

  localparam int unsigned StateW = 32;
  localparam int unsigned ValW   = 16;
  localparam int unsigned ProdW  = StateW + ValW;

  localparam logic [StateW-1:0] LCG_MUL  = 32'd472940017;
  localparam logic [StateW-1:0] LCG_ADD  = 32'd832416023;
  localparam logic [StateW-1:0] LCG_SEED = 32'd1601075945;

  localparam logic [ValW-1:0] RANGE_RST   = 16'd3;
  localparam logic [ValW-1:0] REPEATS_RST = 16'd2;

  // request kinds carried on s_axis_tuser
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  // configuration register indexes
  localparam logic CFG_RANGE   = 1'b0;
  localparam logic CFG_REPEATS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ADV,
    ST_SCALE,
    ST_EVAL,
    ST_FIX,
    ST_DONE
  } fsm_e;

endpackage

`default_nettype wire

// ===== src/random_draw_repeat_limited_core.sv =====
// Repeat-limited random value source.
// Slave stream: one request per beat. s_axis_tuser selects the kind (draw or
// reseed), s_axis_tdata carries the 32-bit seed, used only on reseed.
// Master stream: one 16-bit value per draw request, in 0..range_size-1.
// Config port: cfg_we_i writes cfg_data_i to register cfg_addr_i
// (0 range_size, 1 max_repeats); write only while the block is idle.
// A reseed loads the seed straight from the idle state and gives no result.
// A draw runs on one shared 32x32 multiplier under a small sequencer:
// LCG multiply, add, scale multiply, evaluate; a repeat is replaced by a
// second draw. s_axis_tready is high only while the sequencer is idle, so
// a new request is not taken until the current draw is through. A finished
// result sits in the output register; the next request is taken while it
// waits, and that draw stalls in its last step until the output register
// is free. Reset loads the fixed seed, range 3, repeat limit 2, clears the
// repeat history and empties the output register.
`default_nettype none

module random_draw_repeat_limited_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // config write port
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_addr_i,
  input  wire logic [rdrl_pkg::ValW-1:0] cfg_data_i,
  // requests
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [31:0]               s_axis_tdata,  // [31:0] seed_value
  input  wire logic [0:0]                s_axis_tuser,  // [0] req_type
  // results
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [15:0]                    m_axis_tdata   // [15:0] value
);
  import rdrl_pkg::*;

  fsm_e fsm_q, fsm_d;

  logic [ValW-1:0]   range_q, repeats_q;
  logic [StateW-1:0] lcg_q, lcg_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [ValW-1:0]   sel_range_q, sel_range_d;
  logic [ValW-1:0]   prev_q, prev_d;
  logic [ValW-1:0]   cnt_q, cnt_d;
  logic [ValW-1:0]   f_q, f_d;
  logic              second_q, second_d;
  logic              out_valid_q, out_valid_d;
  logic [ValW-1:0]   out_val_q, out_val_d;

  logic [ValW-1:0]   n, lim, n2, draw_v;
  logic [StateW-1:0] mul_b;
  logic [63:0]       mul_full;
  logic [ValW:0]     sum;
  logic              out_free, req_acc;

  assign n        = (range_q == '0) ? ValW'(1) : range_q;
  assign lim      = (repeats_q == '0) ? ValW'(1) : repeats_q;
  assign n2       = (n == ValW'(1)) ? ValW'(1) : n - ValW'(1);
  assign draw_v   = prod_q[ProdW-1:StateW];
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (fsm_q == ST_IDLE);
  assign req_acc       = s_axis_tvalid && s_axis_tready;

  // shared multiplier: state times LCG constant or state times range
  assign mul_b    = (fsm_q == ST_STEP) ? LCG_MUL : StateW'(sel_range_q);
  assign mul_full = 64'(lcg_q) * 64'(mul_b);

  // modular fix-up of the replacement value, sum < 2n
  always_comb begin
    sum = 17'(draw_v) + 17'(f_q) + 17'd1;
    if (sum >= 17'(n)) begin
      sum = sum - 17'(n);
    end
  end

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      ST_IDLE: begin
        if (req_acc && s_axis_tuser[0] == REQ_DRAW) fsm_d = ST_STEP;
      end
      ST_STEP:  fsm_d = ST_ADV;
      ST_ADV:   fsm_d = ST_SCALE;
      ST_SCALE: fsm_d = second_q ? ST_FIX : ST_EVAL;
      ST_EVAL: begin
        if (draw_v == prev_q && cnt_q >= lim) fsm_d = ST_STEP;
        else fsm_d = ST_DONE;
      end
      ST_FIX:   fsm_d = ST_DONE;
      ST_DONE: begin
        if (out_free) fsm_d = ST_IDLE;
      end
      default:  fsm_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    lcg_d       = lcg_q;
    prod_d      = prod_q;
    sel_range_d = sel_range_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    f_d         = f_q;
    second_d    = second_q;
    out_val_d   = out_val_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (fsm_q)
      ST_IDLE: begin
        if (req_acc) begin
          if (s_axis_tuser[0] == REQ_RESEED) begin
            lcg_d = s_axis_tdata;
          end else begin
            sel_range_d = n;
            second_d    = 1'b0;
          end
        end
      end
      ST_STEP:  prod_d = mul_full[ProdW-1:0];
      ST_ADV:   lcg_d  = prod_q[StateW-1:0] + LCG_ADD;
      ST_SCALE: prod_d = mul_full[ProdW-1:0];
      ST_EVAL: begin
        f_d = draw_v;
        if (draw_v == prev_q) begin
          if (cnt_q >= lim) begin
            sel_range_d = n2;
            second_d    = 1'b1;
          end else begin
            cnt_d  = cnt_q + ValW'(1);
            prev_d = draw_v;
          end
        end else begin
          cnt_d  = ValW'(1);
          prev_d = draw_v;
        end
      end
      ST_FIX: begin
        f_d    = sum[ValW-1:0];
        prev_d = sum[ValW-1:0];
        cnt_d  = ValW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_val_d   = f_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      range_q     <= RANGE_RST;
      repeats_q   <= REPEATS_RST;
      lcg_q       <= LCG_SEED;
      prev_q      <= '0;
      cnt_q       <= '0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      lcg_q       <= lcg_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_RANGE:   range_q   <= cfg_data_i;
          CFG_REPEATS: repeats_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q      <= prod_d;
    sel_range_q <= sel_range_d;
    f_q         <= f_d;
    out_val_q   <= out_val_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_val_q;

  // a delivered value always lies inside the configured range
  a_val_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata < n)
    else $error("result outside range");

  // a draw request keeps the sequencer busy on the next cycle
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_DRAW) |=> !s_axis_tready)
    else $error("draw request did not start sequencer");

  // a reseed loads the generator state
  a_reseed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == REQ_RESEED)
      |=> (lcg_q == $past(s_axis_tdata)))
    else $error("reseed not loaded");

  // once a value went out the repeat count is never zero
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("repeat count zero after a result");

endmodule

`default_nettype wire
